// ===== rtl/core/vdu_pkg.sv =====
// Shared types, widths and codes for the vector distance unit.
`default_nettype none

package vdu_pkg;

    // Field and datapath widths.
    localparam int ELEM_W     = 16;
    localparam int DIFF_W     = ELEM_W + 1;
    localparam int TERM_W     = 35;
    localparam int ACC_W      = 48;
    localparam int ROOT_W     = 38;
    localparam int REM_W      = ROOT_W + 4;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam int CFG_ADDR_W = 3;

    // Metric codes held in the configuration register; code three acts as dot product.
    localparam logic [1:0] METRIC_EUCLID    = 2'd0;
    localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
    localparam logic [1:0] METRIC_DOT       = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_FIN,
        ST_ROOT,
        ST_PUSH
    } vdu_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_term;
        logic acc_update;
        logic root_start;
        logic push_out;
    } vdu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_item;
        logic euclid;
        logic root_done;
        logic out_free;
    } vdu_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/vector_distance_unit.sv =====
// Top level of the vector distance unit: ports, configuration register, assertions.
//
// Usage: pairs of vector elements arrive as beats on the s_ channel, element_a in
// s_tdata[15:0] and element_b in s_tdata[31:16], both signed Q1.14, with s_tlast on
// the final pair. The metric register at address 0 of the APB port selects
// Euclidean distance (0), Manhattan distance (1) or dot product (2, and 3).
// Write it only while no vector is in flight.
// Each pair's term is registered as its beat is taken; the saturating add follows
// in the accumulate state, and no new pair is taken until it is done.
// After the last pair the result beat appears on m_tdata (signed Q19.28) with
// m_tuser set if the accumulator clipped; for Euclidean distance the total first
// passes through the 38-step square-root unit. The next pair is taken once
// the result sits in the output register.
// A stalled receiver holds the result in the output register while the next
// vector streams in; only a further result waits for the slot.
// Reset clears the accumulator, the clip flag, the metric and the output valid.
`default_nettype none

module vector_distance_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // APB configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [vdu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Input channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,   // element_a [15:0], element_b [31:16]
    input  wire logic                           s_tlast,   // last_element
    // Result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [47:0]                         m_tdata,   // distance [47:0]
    output logic                                m_tuser    // saturated [0]
);
    import vdu_pkg::*;

    logic        [1:0] metric_reg;
    logic              cfg_write;
    vdu_cmd_t          cmd;
    vdu_status_t       status;
    vdu_state_t        state;

    // Configuration register; bit 2 of the address picks the register slot.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg <= METRIC_EUCLID;
        end else if (cfg_write) begin
            metric_reg <= pwdata[1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {30'd0, metric_reg};

    vdu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    vdu_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .metric   (metric_reg),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A result beat only ever comes from the hand-off state.
    a_result_from_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state == ST_PUSH))
        else $error("result beat appeared outside the hand-off state");

    // Taking an input beat never launches a result in the following cycle.
    a_no_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result launched right after an input beat");

    // Reset leaves no result pending.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== rtl/core/vdu_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none

module vdu_sqrt (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [vdu_pkg::ACC_W-1:0] radicand,
    output logic                           done,
    output logic [vdu_pkg::ROOT_W-1:0]     root
);
    import vdu_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ACC_W-1:0]  src_reg, src_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    // Bring down the next pair of radicand bits and try the next root bit.
    assign rem_shift = {rem_reg[REM_W-3:0], src_reg[ACC_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            src_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            // Once the radicand is used up, zero pairs shift in for the fraction bits.
            src_next = {src_reg[ACC_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the arithmetic registers are loaded on start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vdu_ctrl.sv =====
// Controller state machine that sequences accumulation, root and result hand-off.
`default_nettype none

module vdu_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire vdu_pkg::vdu_status_t status,
    output vdu_pkg::vdu_cmd_t         cmd,
    output vdu_pkg::vdu_state_t       state
);
    import vdu_pkg::*;

    vdu_state_t state_reg, state_next;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                state_next = status.last_item ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                state_next = status.euclid ? ST_ROOT : ST_PUSH;
            end
            ST_ROOT: begin
                if (status.root_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_term = s_tvalid;
            end
            ST_ACC: begin
                cmd.acc_update = 1'b1;
            end
            ST_FIN: begin
                cmd.root_start = status.euclid;
            end
            ST_ROOT: begin
                cmd = '0;
            end
            ST_PUSH: begin
                cmd.push_out = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/core/vdu_datapath.sv =====
// Term arithmetic, saturating accumulator, square root and output register.
`default_nettype none

module vdu_datapath (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire vdu_pkg::vdu_cmd_t         cmd,
    output vdu_pkg::vdu_status_t           status,
    input  wire logic [1:0]                metric,
    input  wire logic [2*vdu_pkg::ELEM_W-1:0] s_tdata,
    input  wire logic                      s_tlast,
    input  wire logic                      m_tready,
    output logic                           m_tvalid,
    output logic [vdu_pkg::ACC_W-1:0]      m_tdata,
    output logic                           m_tuser
);
    import vdu_pkg::*;

    logic signed [ELEM_W-1:0]   elem_a;
    logic signed [ELEM_W-1:0]   elem_b;
    logic signed [DIFF_W-1:0]   diff;
    logic        [DIFF_W-1:0]   diff_abs;
    logic signed [2*DIFF_W-1:0] diff_sq;
    logic signed [2*ELEM_W-1:0] dot;
    logic signed [TERM_W-1:0]   term;
    logic signed [ACC_W:0]      sum_wide;
    logic signed [ACC_W-1:0]    sum_sat;
    logic                       clip_now;

    logic signed [TERM_W-1:0] term_reg;
    logic                     last_reg;
    logic                     euclid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     clip_reg;
    logic signed [ACC_W-1:0]  fin_reg;
    logic                     fin_clip_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]         out_data_reg;
    logic                     out_sat_reg;

    logic [ACC_W-1:0]  radicand;
    logic [ROOT_W-1:0] root;
    logic              root_done;

    // Per-pair term, straight from the input beat.
    assign elem_a   = s_tdata[ELEM_W-1:0];
    assign elem_b   = s_tdata[2*ELEM_W-1:ELEM_W];
    assign diff     = DIFF_W'(elem_a) - DIFF_W'(elem_b);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign diff_sq  = diff * diff;
    assign dot      = elem_a * elem_b;

    always_comb begin
        case (metric)
            METRIC_EUCLID:    term = TERM_W'(diff_sq);
            METRIC_MANHATTAN: term = {5'b00000, diff_abs[ELEM_W-1:0], 14'b0};
            default:          term = TERM_W'(dot);
        endcase
    end

    // Saturating add of the registered term into the accumulator.
    assign sum_wide = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(term_reg);
    assign clip_now = sum_wide[ACC_W] != sum_wide[ACC_W-1];
    always_comb begin
        if (!clip_now) begin
            sum_sat = sum_wide[ACC_W-1:0];
        end else if (sum_wide[ACC_W]) begin
            sum_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // Operand capture; the metric of the last pair decides the final operation.
    always_ff @(posedge aclk) begin
        if (cmd.load_term) begin
            term_reg   <= term;
            last_reg   <= s_tlast;
            euclid_reg <= (metric == METRIC_EUCLID);
        end
    end

    // Accumulator and clip flag, cleared once a vector's total moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            clip_reg <= 1'b0;
        end else if (cmd.acc_update) begin
            if (last_reg) begin
                acc_reg  <= '0;
                clip_reg <= 1'b0;
            end else begin
                acc_reg  <= sum_sat;
                clip_reg <= clip_reg | clip_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_update && last_reg) begin
            fin_reg      <= sum_sat;
            fin_clip_reg <= clip_reg | clip_now;
        end
    end

    // A negative total has a root of zero.
    assign radicand = fin_reg[ACC_W-1] ? '0 : ACC_W'(fin_reg);

    vdu_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // Output register; the slot frees in the same cycle that its beat is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.push_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_out) begin
            out_data_reg <= euclid_reg ? ACC_W'(root) : ACC_W'(fin_reg);
            out_sat_reg  <= fin_clip_reg;
        end
    end

    assign status.last_item = last_reg;
    assign status.euclid    = euclid_reg;
    assign status.root_done = root_done;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

`default_nettype wire
